// ===== rtl/aligned_memory_fill_splitter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the aligned memory fill splitter
// Shared property wrappers, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ALIGNED_MEMORY_FILL_SPLITTER_CORE_MACROS_SVH
`define ALIGNED_MEMORY_FILL_SPLITTER_CORE_MACROS_SVH

// same-cycle implication
`define AMFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AMFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/amfs_pkg.sv =====
// ----------------------------------------------------------------------------
// amfs_pkg
// Types, size codes and helpers shared by the fill splitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package amfs_pkg;

    localparam logic [1:0] SZ_1 = 2'd0;
    localparam logic [1:0] SZ_2 = 2'd1;
    localparam logic [1:0] SZ_4 = 2'd2;
    localparam logic [1:0] SZ_8 = 2'd3;

    localparam logic [7:0] SMALL_BLOCK_LEN = 8'd32;
    localparam logic [7:0] SHORT_LEN_MAX   = 8'd3;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic [1:0] size;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic [4:0] addr_lo;
        logic [7:0] rem;
    } t_status;

    function automatic logic [7:0] size_step(input logic [1:0] size);
        logic [7:0] step;
        step = 8'd1 << size;
        return step;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/amfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// amfs_ctrl
// Phase sequencer: picks one store per cycle unless stalled; drives o_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module amfs_ctrl
    import amfs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_fill_length,
    input  wire logic       i_stall,
    input  wire t_status    i_status,
    output t_cmd            o_cmd,
    output logic            o_busy,
    output logic            o_valid
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHORT,
        ST_HEAD,
        ST_ALIGN,
        ST_BODY,
        ST_TAIL
    } t_state;

    t_state     r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       slot_free;
    logic       emit;
    logic [1:0] size;
    logic       last;

    assign slot_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        emit    = 1'b0;
        size    = SZ_1;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_fill_length == 8'd0) begin
                        n_state = ST_IDLE;
                    end else if (i_fill_length <= SHORT_LEN_MAX) begin
                        n_state = ST_SHORT;
                    end else begin
                        n_state = ST_HEAD;
                    end
                end
            end
            ST_SHORT: begin
                if (slot_free) begin
                    emit = 1'b1;
                    size = SZ_1;
                end
            end
            ST_HEAD: begin
                if (slot_free) begin
                    if (i_status.addr_lo[0]) begin
                        emit = 1'b1;
                        size = SZ_1;
                    end else if (i_status.addr_lo[1]) begin
                        emit = 1'b1;
                        size = SZ_2;
                    end else if (i_status.rem >= 8'd4 && i_status.addr_lo[2]) begin
                        emit = 1'b1;
                        size = SZ_4;
                    end else if (i_status.rem >= SMALL_BLOCK_LEN) begin
                        n_state = ST_ALIGN;
                    end else begin
                        n_state = ST_BODY;
                    end
                end
            end
            ST_ALIGN: begin
                if (slot_free) begin
                    if (i_status.addr_lo[4:3] != 2'b00) begin
                        emit = 1'b1;
                        size = SZ_8;
                    end else begin
                        n_state = ST_BODY;
                    end
                end
            end
            ST_BODY: begin
                if (slot_free) begin
                    if (i_status.rem >= 8'd8) begin
                        emit = 1'b1;
                        size = SZ_8;
                    end else begin
                        n_state = ST_TAIL;
                    end
                end
            end
            ST_TAIL: begin
                if (slot_free) begin
                    if (i_status.rem[2]) begin
                        emit = 1'b1;
                        size = SZ_4;
                    end else if (i_status.rem[1]) begin
                        emit = 1'b1;
                        size = SZ_2;
                    end else if (i_status.rem[0]) begin
                        emit = 1'b1;
                        size = SZ_1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        last        = emit && (i_status.rem == size_step(size));
        n_out_valid = r_out_valid && i_stall;
        if (emit) begin
            n_out_valid = 1'b1;
        end
        if (last) begin
            n_state = ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd.load = i_valid && (r_state == ST_IDLE);
    assign o_cmd.emit = emit;
    assign o_cmd.size = size;
    assign o_cmd.last = last;
    assign o_busy     = (r_state != ST_IDLE);
    assign o_valid    = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/amfs_dp.sv =====
// ----------------------------------------------------------------------------
// amfs_dp
// Address and byte-count registers, store step, and output store register.
// ----------------------------------------------------------------------------
`default_nettype none

module amfs_dp
    import amfs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic [31:0] i_start_address,
    input  wire logic [7:0]  i_fill_length,
    input  wire logic [7:0]  i_fill_byte,
    input  wire t_cmd        i_cmd,
    output t_status          o_status,
    output logic [31:0]      o_store_address,
    output logic [1:0]       o_store_size,
    output logic [7:0]       o_store_byte,
    output logic             o_last_store
);

    logic [31:0] r_addr;
    logic [7:0]  r_rem;
    logic [7:0]  r_byte;
    logic [31:0] r_out_addr;
    logic [1:0]  r_out_size;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic [7:0]  step;

    assign step = size_step(i_cmd.size);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_start_address;
            r_rem  <= i_fill_length;
            r_byte <= i_fill_byte;
        end else if (i_cmd.emit) begin
            r_addr     <= r_addr + {24'd0, step};
            r_rem      <= r_rem - step;
            r_out_addr <= r_addr;
            r_out_size <= i_cmd.size;
            r_out_byte <= r_byte;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_status.addr_lo = r_addr[4:0];
    assign o_status.rem     = r_rem;
    assign o_store_address  = r_out_addr;
    assign o_store_size     = r_out_size;
    assign o_store_byte     = r_out_byte;
    assign o_last_store     = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/aligned_memory_fill_splitter_core.sv =====
// ----------------------------------------------------------------------------
// aligned_memory_fill_splitter_core
// Splits one fill request into naturally aligned 1/2/4/8-byte stores.
// ----------------------------------------------------------------------------
// A request is taken only while the block is idle (o_stall low). Stores then
// leave one per cycle through a single output register while i_stall is low;
// a phase change in the sequencer (head alignment to 8-byte alignment, to
// body, to tail) is a step without a store. A zero-length request is taken
// and gives nothing. The next request is taken in the cycle after the last
// store enters the output register, while that store is still waiting.
`default_nettype none

module aligned_memory_fill_splitter_core
    import amfs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_start_address,
    input  wire logic [7:0]  i_fill_length,
    input  wire logic [7:0]  i_fill_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_store_address,
    output logic [1:0]       o_store_size,
    output logic [7:0]       o_store_byte,
    output logic             o_last_store
);

`include "aligned_memory_fill_splitter_core_macros.svh"

    t_cmd    cmd;
    t_status status;
    logic    busy;
    logic    start_fill;
    logic    idle_out;
    logic    wide_out;
    logic    store_aligned;

    amfs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_fill_length (i_fill_length),
        .i_stall       (i_stall),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_busy        (busy),
        .o_valid       (o_valid)
    );

    amfs_dp u_dp (
        .i_clk           (i_clk),
        .i_start_address (i_start_address),
        .i_fill_length   (i_fill_length),
        .i_fill_byte     (i_fill_byte),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_store_address (o_store_address),
        .o_store_size    (o_store_size),
        .o_store_byte    (o_store_byte),
        .o_last_store    (o_last_store)
    );

    assign o_stall = busy;

    assign start_fill    = i_valid && !o_stall && (i_fill_length != 8'd0);
    assign idle_out      = o_valid && !o_stall;
    assign wide_out      = o_valid && (o_store_size != SZ_1);
    assign store_aligned = (o_store_size == SZ_2 && o_store_address[0] == 1'b0)
                        || (o_store_size == SZ_4 && o_store_address[1:0] == 2'b00)
                        || (o_store_size == SZ_8 && o_store_address[2:0] == 3'b000);

    `AMFS_ASSERT_NEXT(a_busy_after_load, start_fill, o_stall, "non-empty request did not start")
    `AMFS_ASSERT_NOW(a_idle_only_on_last, idle_out, o_last_store, "non-final store while idle")
    `AMFS_ASSERT_NOW(a_store_aligned, wide_out, store_aligned, "misaligned store")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: aligned fill splitter check
// Sends fill requests over the valid/stall channel and checks every store
// that comes back, field by field, against a behavioural plan of the aligned
// store sequence. A short directed table comes first, then random requests,
// with random gaps on the sending side and random stalls on the receiving side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
    import amfs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 2000;
    localparam int N_RANDOM    = 340;
    localparam int N_DIRECTED  = 23;

    typedef struct packed {
        logic [31:0] addr;
        logic [1:0]  size;
        logic [7:0]  fill;
        logic        last;
    } t_store;

    typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_ONE} t_row_check;

    typedef struct {
        logic [31:0] addr;
        logic [7:0]  len;
        logic [7:0]  fill;
        t_row_check  check;
        logic [1:0]  want_size;
    } t_fill_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_start_address = '0;
    logic [7:0]  i_fill_length = '0;
    logic [7:0]  i_fill_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_store_address;
    logic [1:0]  o_store_size;
    logic [7:0]  o_store_byte;
    logic        o_last_store;

    t_store      pending_stores[$];
    t_store      planned_stores[$];
    logic [31:0] plan_addr;
    logic [7:0]  plan_fill;
    int          error_count = 0;
    int          idle_cycles = 0;
    int          store_index = 0;

    t_fill_row directed_rows [N_DIRECTED] = '{
        '{32'h0000_0000, 8'd0,   8'h00, CHECK_NONE,  SZ_1},
        '{32'hFFFF_FFFF, 8'd0,   8'hFF, CHECK_NONE,  SZ_1},
        '{32'h0000_0010, 8'd1,   8'hA5, CHECK_ONE,   SZ_1},
        '{32'hFFFF_FFFF, 8'd3,   8'h5A, CHECK_MODEL, SZ_1},
        '{32'h0000_0100, 8'd2,   8'h3C, CHECK_MODEL, SZ_1},
        '{32'h0000_0008, 8'd8,   8'hFF, CHECK_ONE,   SZ_8},
        '{32'h0000_0004, 8'd4,   8'h11, CHECK_ONE,   SZ_4},
        '{32'h0000_0002, 8'd4,   8'h22, CHECK_MODEL, SZ_1},
        '{32'h0000_0001, 8'd4,   8'h33, CHECK_MODEL, SZ_1},
        '{32'h0000_0003, 8'd4,   8'h44, CHECK_MODEL, SZ_1},
        '{32'h0000_0000, 8'd255, 8'h00, CHECK_MODEL, SZ_1},
        '{32'hFFFF_FFF1, 8'd255, 8'hFF, CHECK_MODEL, SZ_1},
        '{32'h0000_0008, 8'd40,  8'h81, CHECK_MODEL, SZ_1},
        '{32'h0000_0018, 8'd33,  8'h7F, CHECK_MODEL, SZ_1},
        '{32'h0000_0000, 8'd32,  8'hC3, CHECK_MODEL, SZ_1},
        '{32'h0000_0004, 8'd31,  8'h96, CHECK_MODEL, SZ_1},
        '{32'h8000_0000, 8'd16,  8'h80, CHECK_MODEL, SZ_1},
        '{32'h5555_5555, 8'd200, 8'h55, CHECK_MODEL, SZ_1},
        '{32'hAAAA_AAAA, 8'd100, 8'hAA, CHECK_MODEL, SZ_1},
        '{32'hFFFF_FFFC, 8'd12,  8'h0F, CHECK_MODEL, SZ_1},
        '{32'hFFFF_FFF8, 8'd8,   8'hF0, CHECK_ONE,   SZ_8},
        '{32'h0000_0000, 8'd3,   8'h01, CHECK_MODEL, SZ_1},
        '{32'h0000_0000, 8'd15,  8'h7E, CHECK_MODEL, SZ_1}
    };

    aligned_memory_fill_splitter_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_start_address (i_start_address),
        .i_fill_length   (i_fill_length),
        .i_fill_byte     (i_fill_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_store_address (o_store_address),
        .o_store_size    (o_store_size),
        .o_store_byte    (o_store_byte),
        .o_last_store    (o_last_store)
    );

    always #4 i_clk = ~i_clk;

    task automatic note_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void add_store(input logic [1:0] size);
        t_store s;
        s.addr = plan_addr;
        s.size = size;
        s.fill = plan_fill;
        s.last = 1'b0;
        planned_stores.push_back(s);
        plan_addr = plan_addr + (32'd1 << size);
    endfunction

    // Aligned store sequence for one fill request
    function automatic void plan_stores(input logic [31:0] start, input logic [7:0] len,
                                        input logic [7:0] fill);
        logic [8:0] rem;
        planned_stores.delete();
        plan_addr = start;
        plan_fill = fill;
        rem = {1'b0, len};
        if (len <= SHORT_LEN_MAX) begin
            repeat (len) add_store(SZ_1);
        end else begin
            if (plan_addr[0]) begin
                add_store(SZ_1);
                rem -= 9'd1;
            end
            if (plan_addr[1]) begin
                add_store(SZ_2);
                rem -= 9'd2;
            end
            if (rem >= 9'd4 && plan_addr[2]) begin
                add_store(SZ_4);
                rem -= 9'd4;
            end
            if (rem >= {1'b0, SMALL_BLOCK_LEN}) begin
                if (plan_addr[3]) begin
                    add_store(SZ_8);
                    rem -= 9'd8;
                end
                if (plan_addr[4]) begin
                    add_store(SZ_8);
                    add_store(SZ_8);
                    rem -= 9'd16;
                end
                while (rem >= 9'd32) begin
                    repeat (4) add_store(SZ_8);
                    rem -= 9'd32;
                end
                if (rem[4]) begin
                    add_store(SZ_8);
                    add_store(SZ_8);
                end
                rem = rem & 9'h00F;
            end
            while (rem >= 9'd8) begin
                add_store(SZ_8);
                rem -= 9'd8;
            end
            if (rem[2]) add_store(SZ_4);
            if (rem[1]) add_store(SZ_2);
            if (rem[0]) add_store(SZ_1);
        end
        if (planned_stores.size() > 0)
            planned_stores[planned_stores.size() - 1].last = 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 95) return $urandom_range(4, 10);
        else return $urandom_range(20, 40);
    endfunction

    task automatic issue_fill(input logic [31:0] addr, input logic [7:0] len,
                              input logic [7:0] fill, input int gap,
                              input t_row_check check, input logic [1:0] want_size);
        t_store s;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_start_address <= addr;
        i_fill_length   <= len;
        i_fill_byte     <= fill;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        plan_stores(addr, len, fill);
        case (check)
            CHECK_MODEL: begin
                foreach (planned_stores[i]) pending_stores.push_back(planned_stores[i]);
            end
            CHECK_ONE: begin
                s.addr = addr;
                s.size = want_size;
                s.fill = fill;
                s.last = 1'b1;
                pending_stores.push_back(s);
            end
            default: ;
        endcase
    endtask

    // store checker
    always @(posedge i_clk) begin
        t_store want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_stores.size() == 0) begin
                note_error($sformatf("unexpected store addr %h size %0d",
                                     o_store_address, o_store_size));
            end else begin
                want = pending_stores.pop_front();
                if (o_store_address !== want.addr)
                    note_error($sformatf("store %0d addr %h, want %h",
                                         store_index, o_store_address, want.addr));
                if (o_store_size !== want.size)
                    note_error($sformatf("store %0d size %0d, want %0d",
                                         store_index, o_store_size, want.size));
                if (o_store_byte !== want.fill)
                    note_error($sformatf("store %0d fill %h, want %h",
                                         store_index, o_store_byte, want.fill));
                if (o_last_store !== want.last)
                    note_error($sformatf("store %0d last %b, want %b",
                                         store_index, o_last_store, want.last));
            end
            store_index <= store_index + 1;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("aligned_memory_fill_splitter_core: mismatch");
                $finish;
            end
        end
    end

    initial begin : receiver
        int run;
        int hold;
        @(posedge i_rst_n);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            i_stall <= 1'b0;
            repeat (run) @(posedge i_clk);
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
            i_stall <= 1'b1;
            repeat (hold) @(posedge i_clk);
        end
    end

    initial begin : sender
        logic [31:0] addr;
        logic [7:0]  len;
        logic [7:0]  fill;
        int          r;
        int          gap;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            issue_fill(directed_rows[i].addr, directed_rows[i].len, directed_rows[i].fill,
                       pick_gap(), directed_rows[i].check, directed_rows[i].want_size);

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k > 0 && k % 100 == 0) begin
                // drain completely before carrying on
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_stores.size() != 0) @(posedge i_clk);
            end
            r = $urandom_range(0, 9);
            if (r == 0) addr = 32'hFFFF_FFC0 | $urandom_range(0, 63);
            else if (r == 1) addr = $urandom_range(0, 255);
            else addr = $urandom();
            r = $urandom_range(0, 19);
            if (r < 3) begin
                len = 8'($urandom_range(0, 3));
            end else if (r < 9) begin
                len = 8'($urandom_range(4, 48));
            end else if (r == 9) begin
                case ($urandom_range(0, 5))
                    0: len = 8'd0;
                    1: len = 8'd255;
                    2: len = 8'd31;
                    3: len = 8'd32;
                    4: len = 8'd33;
                    default: len = 8'd48;
                endcase
            end else begin
                len = 8'($urandom_range(0, 255));
            end
            fill = 8'($urandom_range(0, 255));
            gap = ((k / 40) % 3 == 1) ? 0 : pick_gap();
            issue_fill(addr, len, fill, gap, CHECK_MODEL, SZ_1);
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_stores.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("aligned_memory_fill_splitter_core: match");
        else
            $display("aligned_memory_fill_splitter_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/amfs_pkg.sv
rtl/amfs_ctrl.sv
rtl/amfs_dp.sv
rtl/aligned_memory_fill_splitter_core.sv
tb/tb_top.sv
